FILE: hdl/v4alu_pkg.sv
// ----------------------------------------------------------------------------
// v4alu_pkg
// Shared command codes, status codes and default widths of the vector ALU.
// ----------------------------------------------------------------------------
package v4alu_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int LANES          = 4;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_SCALE = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_NEG   = 4'd4,
        CMD_MAG   = 4'd5,
        CMD_NORM  = 4'd6,
        CMD_DOT   = 4'd7,
        CMD_CROSS = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

endpackage

FILE: hdl/vec4_alu.sv
// ----------------------------------------------------------------------------
// vec4_alu: four-component fixed-point vector ALU
// Accepted beats pass the input register, the lane and merge stages, the
// square root and divider pipelines and then the output register.
// Throughput: one beat per cycle; the whole pipeline holds only while a
// result waits at the output. Reset clears all valid flags, not data.
// ----------------------------------------------------------------------------
module vec4_alu #(
    parameter int WORD_WIDTH = v4alu_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = v4alu_pkg::FRAC_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (lowest bits first)
    input  logic [8*WORD_WIDTH-1:0]                  s_tdata,
    // cmd
    input  logic [3:0]                               s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // r_x, r_y, r_z, r_w, r_scalar (lowest bits first), zero padded to bytes
    output logic [((5*WORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    // status
    output logic [1:0]                               m_tuser
);
    import v4alu_pkg::*;

    localparam int W      = WORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int PW     = 2 * W;
    localparam int NS     = W + 1;           // square root stages (root bits)
    localparam int NQ     = W + F;           // divider stages (quotient bits)
    localparam int PD     = 4 + NS + NQ;     // stages ahead of the output register
    localparam int OUT_DW = ((5*W+7)/8)*8;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        cmd_t                  cmd;
        logic [LANES-1:0][W-1:0] a;
        logic [W-1:0]          bx;
    } opnd_t;

    // Everything an item still needs once the lanes have done their early work.
    typedef struct packed {
        cmd_t                  cmd;
        logic [LANES-1:0][W-1:0] a;
        logic [W-1:0]          bx;
        logic [LANES-1:0][W-1:0] r;
        logic [W-1:0]          sc;
        logic                  ovf;
        logic                  mzero;
    } side_t;

    // The pipeline moves as one: it advances whenever the output register is
    // free or being emptied in this cycle.
    logic adv;
    logic m_tvalid_reg;
    logic [PD-1:0] vld_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[PD-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PD-1];
        end
    end

    // Input stage: unpack the beat.
    opnd_t                   op_a_reg, op_b_reg, op_c_reg;
    logic [LANES-1:0][W-1:0] b_a_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_a_reg.cmd <= cmd_t'(s_tuser);
            for (int i = 0; i < LANES; i++) begin
                op_a_reg.a[i] <= s_tdata[i*W +: W];
                b_a_reg[i]    <= s_tdata[(LANES+i)*W +: W];
            end
            op_a_reg.bx <= s_tdata[LANES*W +: W];
            op_b_reg    <= op_a_reg;
            op_c_reg    <= op_b_reg;
        end
    end

    // Four lanes, one per component. Lanes x, y and z also compute the two
    // products of their cross term; lane w gets zero operands there.
    logic signed [PW-1:0] lane_prod    [LANES];
    logic [W-1:0]         lane_early_r [LANES];
    logic [LANES-1:0]     lane_early_ovf;
    logic [W-1:0]         lane_quo_r   [LANES];
    logic [LANES-1:0]     lane_quo_ovf;
    side_t                sq_out;
    logic [W:0]           den_c;
    logic                 den_neg_c;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        logic [W-1:0] c0a, c0b, c1a, c1b;

        if (i < 3) begin : g_cross
            assign c0a = op_a_reg.a[J];
            assign c0b = b_a_reg[K];
            assign c1a = op_a_reg.a[K];
            assign c1b = b_a_reg[J];
        end else begin : g_flat
            assign c0a = '0;
            assign c0b = '0;
            assign c1a = '0;
            assign c1b = '0;
        end

        v4alu_lane #(
            .WORD_WIDTH (W),
            .FRAC_BITS  (F)
        ) u_lane (
            .aclk      (aclk),
            .en        (adv),
            .cmd       (op_a_reg.cmd),
            .a_in      (op_a_reg.a[i]),
            .b_in      (b_a_reg[i]),
            .bx_in     (op_a_reg.bx),
            .c0a_in    (c0a),
            .c0b_in    (c0b),
            .c1a_in    (c1a),
            .c1b_in    (c1b),
            .prod      (lane_prod[i]),
            .early_r   (lane_early_r[i]),
            .early_ovf (lane_early_ovf[i]),
            .div_a     (sq_out.a[i]),
            .div_den   (den_c),
            .den_neg   (den_neg_c),
            .quo_r     (lane_quo_r[i]),
            .quo_ovf   (lane_quo_ovf[i])
        );
    end

    // Merge tree for dot and magnitude: pair sums, then the full sum.
    logic signed [PW:0]   ps0_reg, ps1_reg;
    logic signed [PW+1:0] tot_c, dot_sh;
    logic [PW+1:0]        tot_reg;
    logic                 dot_ovf;
    logic [W-1:0]         dot_sat;
    side_t                side_d_c, side_d_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ps0_reg <= (PW+1)'(lane_prod[0]) + (PW+1)'(lane_prod[1]);
            ps1_reg <= (PW+1)'(lane_prod[2]) + (PW+1)'(lane_prod[3]);
        end
    end

    // The floored shift of the exact sum equals the sum of floored parts
    // plus the carried-out fractions.
    assign tot_c   = (PW+2)'(ps0_reg) + (PW+2)'(ps1_reg);
    assign dot_sh  = tot_c >>> F;
    assign dot_ovf = !((&dot_sh[PW+1:W-1]) || !(|dot_sh[PW+1:W-1]));
    assign dot_sat = dot_ovf ? (dot_sh[PW+1] ? SMIN : SMAX) : dot_sh[W-1:0];

    always_comb begin
        side_d_c.cmd   = op_c_reg.cmd;
        side_d_c.a     = op_c_reg.a;
        side_d_c.bx    = op_c_reg.bx;
        for (int i = 0; i < LANES; i++) begin
            side_d_c.r[i] = lane_early_r[i];
        end
        side_d_c.sc    = (op_c_reg.cmd == CMD_DOT) ? dot_sat : '0;
        side_d_c.ovf   = (|lane_early_ovf) || ((op_c_reg.cmd == CMD_DOT) && dot_ovf);
        side_d_c.mzero = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_d_reg <= side_d_c;
            tot_reg    <= tot_c;
        end
    end

    // Magnitude: the sum of squares is never negative and fits PW+1 bits.
    logic [NS-1:0] root;

    v4alu_sqrt #(
        .ROOT_W (NS)
    ) u_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand ((2*NS)'(tot_reg[PW:0])),
        .root     (root)
    );

    side_t sq_line_reg [NS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_line_reg[0] <= side_d_reg;
            for (int k = 1; k < NS; k++) begin
                sq_line_reg[k] <= sq_line_reg[k-1];
            end
        end
    end

    // After the root: fill in the magnitude and pick the divisor. Divide
    // uses |b_x|, normalize the unsaturated magnitude.
    logic         mag_ovf;
    logic [W-1:0] mag_sat;
    logic [W:0]   bx_ext;
    side_t        side_m_c;

    assign sq_out  = sq_line_reg[NS-1];
    assign mag_ovf = root[W] || root[W-1];
    assign mag_sat = mag_ovf ? SMAX : root[W-1:0];
    assign bx_ext  = (W+1)'($signed(sq_out.bx));

    always_comb begin
        side_m_c       = sq_out;
        side_m_c.mzero = (root == '0);
        if (sq_out.cmd == CMD_MAG) begin
            side_m_c.sc  = mag_sat;
            side_m_c.ovf = mag_ovf;
        end
        if (sq_out.cmd == CMD_DIV) begin
            den_c     = sq_out.bx[W-1] ? (W+1)'(-bx_ext) : bx_ext;
            den_neg_c = sq_out.bx[W-1];
        end else begin
            den_c     = root;
            den_neg_c = 1'b0;
        end
    end

    side_t dv_line_reg [NQ];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_line_reg[0] <= side_m_c;
            for (int k = 1; k < NQ; k++) begin
                dv_line_reg[k] <= dv_line_reg[k-1];
            end
        end
    end

    // Final merge of the lane results into one beat. A zero divisor outranks
    // any overflow the quotients might show.
    side_t                   side_q;
    logic [LANES-1:0][W-1:0] r_c;
    logic [W-1:0]            sc_c;
    status_t                 st_c;

    assign side_q = dv_line_reg[NQ-1];

    always_comb begin
        r_c  = side_q.r;
        sc_c = side_q.sc;
        st_c = side_q.ovf ? ST_OVF : ST_OK;
        unique case (side_q.cmd)
            CMD_DIV: begin
                if (side_q.bx == '0) begin
                    st_c = ST_DIV0;
                    for (int i = 0; i < LANES; i++) begin
                        if (side_q.a[i][W-1]) begin
                            r_c[i] = SMIN;
                        end else if (|side_q.a[i]) begin
                            r_c[i] = SMAX;
                        end else begin
                            r_c[i] = '0;
                        end
                    end
                end else begin
                    for (int i = 0; i < LANES; i++) begin
                        r_c[i] = lane_quo_r[i];
                    end
                    st_c = (|lane_quo_ovf) ? ST_OVF : ST_OK;
                end
            end
            CMD_NORM: begin
                if (side_q.mzero) begin
                    st_c = ST_DIV0;
                    r_c  = '0;
                end else begin
                    for (int i = 0; i < LANES; i++) begin
                        r_c[i] = lane_quo_r[i];
                    end
                    st_c = (|lane_quo_ovf) ? ST_OVF : ST_OK;
                end
            end
            default: ;
        endcase
    end

    logic [5*W-1:0] m_data_reg;
    status_t        m_st_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {sc_c, r_c[3], r_c[2], r_c[1], r_c[0]};
            m_st_reg   <= st_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DW'(m_data_reg);
    assign m_tuser  = m_st_reg;

`ifndef NO_ASSERTIONS
    // A held output must freeze every stage behind it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid flags moved during a stall");

    // Only divide and normalize may report a zero divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[PD-1] && side_q.cmd != CMD_DIV && side_q.cmd != CMD_NORM
        |-> st_c != ST_DIV0)
        else $error("zero divisor status on a command without a divisor");

    // The scalar result belongs to magnitude and dot alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[PD-1] && side_q.cmd != CMD_MAG && side_q.cmd != CMD_DOT
        |-> sc_c == '0)
        else $error("scalar result set for a tuple command");

    // Cross product leaves the w component at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[PD-1] && side_q.cmd == CMD_CROSS |-> r_c[3] == '0)
        else $error("cross product produced a nonzero w");
`endif

endmodule

FILE: hdl/v4alu_sqrt.sv
// ----------------------------------------------------------------------------
// v4alu_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v4alu_sqrt #(
    parameter int ROOT_W = v4alu_pkg::WORD_WIDTH_DEF + 1
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root
);
    import v4alu_pkg::*;

    localparam int NUM_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [NUM_W-1:0]  num_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    logic [NUM_W-1:0]  num_in   [ROOT_W];
    logic [REM_W-1:0]  rem_in   [ROOT_W];
    logic [ROOT_W-1:0] root_in  [ROOT_W];
    logic [NUM_W-1:0]  num_next [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_next[ROOT_W];

    always_comb begin
        num_in[0]  = radicand;
        rem_in[0]  = '0;
        root_in[0] = '0;
        for (int k = 1; k < ROOT_W; k++) begin
            num_in[k]  = num_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++) begin
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            logic             take;
            // Bring down the next bit pair and try the digit one.
            rem_sh = {rem_in[k][REM_W-3:0], num_in[k][NUM_W-1 -: 2]};
            trial  = REM_W'({root_in[k], 2'b01});
            take   = (rem_sh >= trial);
            rem_next[k]  = take ? (rem_sh - trial) : rem_sh;
            root_next[k] = {root_in[k][ROOT_W-2:0], take};
            num_next[k]  = {num_in[k][NUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                num_reg[k]  <= num_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

FILE: hdl/v4alu_div.sv
// ----------------------------------------------------------------------------
// v4alu_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v4alu_div #(
    parameter int NUM_W = v4alu_pkg::WORD_WIDTH_DEF + v4alu_pkg::FRAC_BITS_DEF,
    parameter int DEN_W = v4alu_pkg::WORD_WIDTH_DEF + 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg_in,
    output logic [NUM_W-1:0] quo,
    output logic             neg_out
);
    import v4alu_pkg::*;

    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic             neg_reg [NUM_W];

    logic [NUM_W-1:0] num_in  [NUM_W];
    logic [DEN_W-1:0] rem_in  [NUM_W];
    logic [NUM_W-1:0] quo_in  [NUM_W];
    logic [DEN_W-1:0] den_in  [NUM_W];
    logic             neg_i   [NUM_W];
    logic [NUM_W-1:0] num_next[NUM_W];
    logic [DEN_W-1:0] rem_next[NUM_W];
    logic [NUM_W-1:0] quo_next[NUM_W];

    always_comb begin
        num_in[0] = num;
        rem_in[0] = '0;
        quo_in[0] = '0;
        den_in[0] = den;
        neg_i[0]  = neg_in;
        for (int k = 1; k < NUM_W; k++) begin
            num_in[k] = num_reg[k-1];
            rem_in[k] = rem_reg[k-1];
            quo_in[k] = quo_reg[k-1];
            den_in[k] = den_reg[k-1];
            neg_i[k]  = neg_reg[k-1];
        end
        for (int k = 0; k < NUM_W; k++) begin
            logic [DEN_W+1:0] rem_sh;
            logic [DEN_W+1:0] rem_sub;
            rem_sh  = {1'b0, rem_in[k], num_in[k][NUM_W-1]};
            rem_sub = rem_sh - (DEN_W+2)'(den_in[k]);
            // A borrow means the divisor did not fit: keep the remainder.
            rem_next[k] = rem_sub[DEN_W+1] ? rem_sh[DEN_W-1:0] : rem_sub[DEN_W-1:0];
            quo_next[k] = {quo_in[k][NUM_W-2:0], ~rem_sub[DEN_W+1]};
            num_next[k] = {num_in[k][NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_W; k++) begin
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_in[k];
                neg_reg[k] <= neg_i[k];
            end
        end
    end

    assign quo     = quo_reg[NUM_W-1];
    assign neg_out = neg_reg[NUM_W-1];

endmodule

FILE: hdl/v4alu_lane.sv
// ----------------------------------------------------------------------------
// v4alu_lane
// One component lane: add, subtract, negate, scale, cross term, the product
// for dot and magnitude, and a divider for divide and normalize.
// ----------------------------------------------------------------------------
module v4alu_lane #(
    parameter int WORD_WIDTH = v4alu_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = v4alu_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           en,
    input  v4alu_pkg::cmd_t                cmd,
    input  logic signed [WORD_WIDTH-1:0]   a_in,
    input  logic signed [WORD_WIDTH-1:0]   b_in,
    input  logic signed [WORD_WIDTH-1:0]   bx_in,
    input  logic signed [WORD_WIDTH-1:0]   c0a_in,
    input  logic signed [WORD_WIDTH-1:0]   c0b_in,
    input  logic signed [WORD_WIDTH-1:0]   c1a_in,
    input  logic signed [WORD_WIDTH-1:0]   c1b_in,
    output logic signed [2*WORD_WIDTH-1:0] prod,
    output logic [WORD_WIDTH-1:0]          early_r,
    output logic                           early_ovf,
    input  logic signed [WORD_WIDTH-1:0]   div_a,
    input  logic [WORD_WIDTH:0]            div_den,
    input  logic                           den_neg,
    output logic [WORD_WIDTH-1:0]          quo_r,
    output logic                           quo_ovf
);
    import v4alu_pkg::*;

    localparam int W     = WORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int PW    = 2 * W;
    localparam int NUM_W = W + F;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    // First stage: operand selection, the two multipliers, simple ops.
    logic signed [W-1:0]  mx0, my0;
    logic signed [W:0]    simp;
    logic signed [PW-1:0] p0_c, p1_c;
    logic                 simp_ovf_c;
    logic [W-1:0]         simp_r_c;

    always_comb begin
        mx0  = a_in;
        my0  = b_in;
        simp = '0;
        unique case (cmd)
            CMD_ADD:  simp = (W+1)'(a_in) + (W+1)'(b_in);
            CMD_SUB:  simp = (W+1)'(a_in) - (W+1)'(b_in);
            CMD_NEG:  simp = -((W+1)'(a_in));
            CMD_SCALE: my0 = bx_in;
            CMD_MAG, CMD_NORM: my0 = a_in;
            CMD_CROSS: begin
                mx0 = c0a_in;
                my0 = c0b_in;
            end
            default: ;
        endcase
    end

    assign p0_c       = PW'(mx0) * PW'(my0);
    assign p1_c       = PW'(c1a_in) * PW'(c1b_in);
    assign simp_ovf_c = (simp[W] != simp[W-1]);
    assign simp_r_c   = simp_ovf_c ? (simp[W] ? SMIN : SMAX) : simp[W-1:0];

    logic signed [PW-1:0] p0_reg, p1_reg;
    logic [W-1:0]         simp_r_reg;
    logic                 simp_ovf_reg;
    cmd_t                 cmd_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg       <= p0_c;
            p1_reg       <= p1_c;
            simp_r_reg   <= simp_r_c;
            simp_ovf_reg <= simp_ovf_c;
            cmd_b_reg    <= cmd;
        end
    end

    assign prod = p0_reg;

    // Second stage: cross difference or scale product, shifted and saturated.
    logic signed [PW:0] diff, selv, shv;
    logic               sh_ovf;
    logic [W-1:0]       sh_r;

    assign diff   = (PW+1)'(p0_reg) - (PW+1)'(p1_reg);
    assign selv   = (cmd_b_reg == CMD_CROSS) ? diff : (PW+1)'(p0_reg);
    assign shv    = selv >>> F;
    assign sh_ovf = !((&shv[PW:W-1]) || !(|shv[PW:W-1]));
    assign sh_r   = sh_ovf ? (shv[PW] ? SMIN : SMAX) : shv[W-1:0];

    logic [W-1:0] early_r_reg;
    logic         early_ovf_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (cmd_b_reg)
                CMD_ADD, CMD_SUB, CMD_NEG: begin
                    early_r_reg   <= simp_r_reg;
                    early_ovf_reg <= simp_ovf_reg;
                end
                CMD_SCALE, CMD_CROSS: begin
                    early_r_reg   <= sh_r;
                    early_ovf_reg <= sh_ovf;
                end
                default: begin
                    early_r_reg   <= '0;
                    early_ovf_reg <= 1'b0;
                end
            endcase
        end
    end

    assign early_r   = early_r_reg;
    assign early_ovf = early_ovf_reg;

    // Quotient path: magnitudes through the divider, sign applied afterwards.
    logic [W-1:0]     abs_a;
    logic [NUM_W-1:0] quo_mag;
    logic             quo_neg;

    assign abs_a = div_a[W-1] ? W'(-div_a) : div_a;

    v4alu_div #(
        .NUM_W (NUM_W),
        .DEN_W (W + 1)
    ) u_div (
        .aclk    (aclk),
        .en      (en),
        .num     ({abs_a, {F{1'b0}}}),
        .den     (div_den),
        .neg_in  (div_a[W-1] ^ den_neg),
        .quo     (quo_mag),
        .neg_out (quo_neg)
    );

    always_comb begin
        if (quo_neg) begin
            // The most negative word is still reachable.
            quo_ovf = (|quo_mag[NUM_W-1:W]) || (quo_mag[W-1] && (|quo_mag[W-2:0]));
            quo_r   = quo_ovf ? SMIN : W'(-quo_mag[W-1:0]);
        end else begin
            quo_ovf = |quo_mag[NUM_W-1:W-1];
            quo_r   = quo_ovf ? SMAX : quo_mag[W-1:0];
        end
    end

endmodule
